/* design/access_hotness_pattern_tracker_assert.svh */
// Assertion macros for the access hotness and pattern tracker.
// Used by the checker module; no other dependencies.
`ifndef ACCESS_HOTNESS_PATTERN_TRACKER_ASSERT_SVH
`define ACCESS_HOTNESS_PATTERN_TRACKER_ASSERT_SVH

// Same-cycle implication.
`define AHPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ahpt check failed");

// Next-cycle implication.
`define AHPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ahpt check failed");

`endif

/* design/ahpt_pkg.sv */
// Shared types and constants of the access hotness and pattern tracker.
// No dependencies.
package ahpt_pkg;

    localparam int DIV_W       = 72;
    localparam int DIV_CNT_W   = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] REUSE_CAP     = 16'd62259;
    localparam logic [31:0] BONUS_Q16     = 32'd13107;
    localparam logic [31:0] COMPUTE_LIMIT = 32'd1000;
    localparam logic [19:0] FREQ_SCALE    = 20'd1000000;
    // ceil(2^37/10): (x*SCORE_RECIP)>>37 is x/10 for x below 2^34
    localparam logic [33:0] SCORE_RECIP   = 34'd13743895348;

    localparam logic [2:0] PAT_UNKNOWN  = 3'd0;
    localparam logic [2:0] PAT_SEQ      = 3'd1;
    localparam logic [2:0] PAT_STRIDED  = 3'd2;
    localparam logic [2:0] PAT_TEMPORAL = 3'd3;
    localparam logic [2:0] PAT_RANDOM   = 3'd4;

    typedef struct packed {
        logic [63:0] handle;
        logic [63:0] now;
        logic        bonus;
    } t_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     num;
        logic [63:0]          den;
        logic [DIV_CNT_W-1:0] bits;
    } t_div_req;

    // 0.5 + 0.045*count in Q0.16 from count 2 (0 below), capped at 0.95 (reached from count 10)
    function automatic logic [15:0] reuse_value(input logic [31:0] cnt);
        logic [15:0] v;
        if (cnt >= 32'd10) begin
            v = REUSE_CAP;
        end else begin
            unique case (cnt[3:0])
                4'd2: v = 16'd38666;
                4'd3: v = 16'd41615;
                4'd4: v = 16'd44564;
                4'd5: v = 16'd47513;
                4'd6: v = 16'd50462;
                4'd7: v = 16'd53411;
                4'd8: v = 16'd56360;
                4'd9: v = 16'd59310;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

/* design/ahpt_front.sv */
// Front stage: takes input transactions and flags the compute bonus.
// Depends on ahpt_pkg.
module ahpt_front import ahpt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_tensor_handle,
    input  logic [63:0] i_now_us,
    input  logic [31:0] i_compute_time_us,
    output logic        o_push,
    output t_item       o_item,
    input  logic        i_push_ready
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.handle <= i_tensor_handle;
            r_item.now    <= i_now_us;
            r_item.bonus  <= (i_compute_time_us > COMPUTE_LIMIT);
        end
    end

endmodule

/* design/ahpt_queue.sv */
// Short queue between front and back.
// Depends on ahpt_pkg.
module ahpt_queue import ahpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_push_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_item          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [AW:0]    r_cnt;
    logic           push;
    logic           pop;

    assign o_push_ready = (r_cnt != (AW+1)'(QUEUE_DEPTH));
    assign o_valid      = (r_cnt != '0);
    assign o_item       = r_mem[r_rd];
    assign push         = i_push && o_push_ready;
    assign pop          = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* design/ahpt_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
// Dividend arrives left aligned; depends on ahpt_pkg.
module ahpt_divider import ahpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_W-1:0]     r_num;
    logic [63:0]          r_rem;
    logic [63:0]          r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [64:0]          rem2;
    logic                 ge;
    logic [64:0]          rem_n;

    assign rem2   = {r_rem, r_num[DIV_W-1]};
    assign ge     = (rem2 >= {1'b0, r_den});
    assign rem_n  = ge ? (rem2 - {1'b0, r_den}) : rem2;
    assign o_done = r_done;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_cnt <= i_req.bits;
        end else if (r_busy) begin
            r_rem <= rem_n[63:0];
            r_num <= {r_num[DIV_W-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

/* design/ahpt_back.sv */
// Back engine: table search, interval window, statistics and result register.
// Depends on ahpt_pkg; drives the shared ahpt_divider.
module ahpt_back import ahpt_pkg::*; #(
    parameter int TABLE_ENTRIES    = 64,
    parameter int WINDOW_INTERVALS = 100
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [63:0]      i_start_time,
    input  logic             i_q_valid,
    input  t_item            i_q_item,
    output logic             o_q_pop,
    output t_div_req         o_div_req,
    input  logic             i_div_done,
    input  logic [DIV_W-1:0] i_div_quot,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_tracked,
    output logic [31:0]      o_access_total,
    output logic [31:0]      o_access_frequency,
    output logic [15:0]      o_reuse_probability,
    output logic [63:0]      o_expected_next_us,
    output logic [31:0]      o_residency_score,
    output logic [2:0]       o_access_pattern
);

    localparam int IDX_W     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W     = $clog2(TABLE_ENTRIES + 1);
    localparam int FILL_W    = $clog2(WINDOW_INTERVALS + 1);
    localparam int HEAD_W    = $clog2(WINDOW_INTERVALS);
    localparam int WIN_DEPTH = TABLE_ENTRIES * WINDOW_INTERVALS;
    localparam int WADDR_W   = $clog2(WIN_DEPTH);
    localparam int SUM_W     = 32 + FILL_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SCAN   = 5'd1;
    localparam logic [4:0] S_SCMP   = 5'd2;
    localparam logic [4:0] S_DECIDE = 5'd3;
    localparam logic [4:0] S_ERD    = 5'd4;
    localparam logic [4:0] S_EGET   = 5'd5;
    localparam logic [4:0] S_FSTART = 5'd6;
    localparam logic [4:0] S_DWAIT  = 5'd7;
    localparam logic [4:0] S_FDONE  = 5'd8;
    localparam logic [4:0] S_REUSE  = 5'd9;
    localparam logic [4:0] S_SUM    = 5'd10;
    localparam logic [4:0] S_MSTART = 5'd11;
    localparam logic [4:0] S_MDONE  = 5'd12;
    localparam logic [4:0] S_VAR    = 5'd13;
    localparam logic [4:0] S_VSTART = 5'd14;
    localparam logic [4:0] S_CLS    = 5'd15;
    localparam logic [4:0] S_CLS2   = 5'd16;
    localparam logic [4:0] S_SSTART = 5'd17;
    localparam logic [4:0] S_SDONE  = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;
    localparam logic [4:0] S_SMUL   = 5'd20;

    typedef struct packed {
        logic [63:0]       last;
        logic [31:0]       count;
        logic [31:0]       freq;
        logic [15:0]       reuse;
        logic [63:0]       next;
        logic [FILL_W-1:0] fill;
        logic [HEAD_W-1:0] head;
    } t_entry;

    typedef struct packed {
        logic        tracked;
        logic [31:0] total;
        logic [31:0] freq;
        logic [15:0] reuse;
        logic [63:0] next;
        logic [31:0] score;
        logic [2:0]  pattern;
    } t_result;

    logic [63:0] tag_mem [TABLE_ENTRIES];
    t_entry      ent_mem [TABLE_ENTRIES];
    logic [31:0] win_mem [WIN_DEPTH];

    logic [4:0]               r_state;
    logic [4:0]               r_ret;
    t_item                    r_item;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]         r_idx;
    logic                     r_found;
    logic                     r_free_ok;
    logic [IDX_W-1:0]         r_free;
    logic [IDX_W-1:0]         r_e;
    logic                     r_new;
    logic [63:0]              r_tag_q;
    t_entry                   r_ent_q;
    t_entry                   r_rec;
    logic [31:0]              r_win_q;
    logic [WADDR_W-1:0]       r_base;
    logic [51:0]              r_prod;
    logic [63:0]              r_elapsed;
    logic [DIV_W-1:0]         r_quot;
    logic [FILL_W-1:0]        r_ri;
    logic                     r_p1;
    logic                     r_p2;
    logic [SUM_W-1:0]         r_sum;
    logic [31:0]              r_mean;
    logic [63:0]              r_msq;
    logic [63:0]              r_sq;
    logic [DIV_W-1:0]         r_acc;
    logic [DIV_W-1:0]         r_v100;
    logic [DIV_W-1:0]         r_m9;
    logic [2:0]               r_pat;
    logic [67:0]              r_sprod;
    t_result                  r_res;
    logic                     r_o_valid;
    t_result                  r_out;

    logic [IDX_W-1:0]   idx;
    logic               tag_rd_en;
    logic               tag_wr_en;
    logic               ent_rd_en;
    logic               ent_wr_en;
    logic               win_rd_en;
    logic               win_wr_en;
    logic [WADDR_W-1:0] win_addr;
    t_entry             cur;
    logic [63:0]        iv_full;
    logic [31:0]        iv;
    logic               push;
    logic [31:0]        new_count;
    logic [31:0]        diff;
    logic [33:0]        f3;
    logic [16:0]        smul_in;
    logic [50:0]        smul;
    logic [33:0]        score;
    logic [63:0]        var_q;

    assign idx       = r_idx[IDX_W-1:0];
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign tag_rd_en = (r_state == S_SCAN) && (r_idx != CNT_W'(TABLE_ENTRIES)) && r_valid[idx];
    assign tag_wr_en = (r_state == S_DECIDE) && !r_found && r_free_ok;
    assign ent_rd_en = (r_state == S_ERD);
    assign ent_wr_en = (r_state == S_SDONE);

    assign cur       = r_new ? '0 : r_ent_q;
    assign iv_full   = r_item.now - cur.last;
    assign iv        = (iv_full[63:32] != '0) ? '1 : iv_full[31:0];
    assign push      = (cur.last != '0);
    assign new_count = (cur.count == '1) ? cur.count : cur.count + 1'b1;
    assign diff      = (r_win_q >= r_mean) ? (r_win_q - r_mean) : (r_mean - r_win_q);
    assign f3        = {2'b0, r_rec.freq} + {1'b0, r_rec.freq, 1'b0};
    // freq*3/10 by reciprocal, one 17-bit half of f3 per cycle
    assign smul_in   = (r_state == S_SSTART) ? f3[16:0] : f3[33:17];
    assign smul      = smul_in * SCORE_RECIP;
    assign score     = {3'b0, r_sprod[67:37]} + 34'(r_rec.reuse[15:1])
                     + (r_item.bonus ? 34'(BONUS_Q16) : 34'd0);
    assign var_q     = r_quot[63:0];

    assign win_wr_en = (r_state == S_EGET) && push;
    assign win_rd_en = ((r_state == S_SUM) || (r_state == S_VAR)) && (r_ri != r_rec.fill);
    assign win_addr  = win_wr_en ? (r_base + WADDR_W'(cur.head)) : (r_base + WADDR_W'(r_ri));

    always_comb begin
        o_div_req = '0;
        unique case (r_state)
            S_FSTART: begin
                o_div_req.start = (r_elapsed != '0);
                o_div_req.num   = {r_prod, 20'b0};
                o_div_req.den   = r_elapsed;
                o_div_req.bits  = DIV_CNT_W'(68);
            end
            S_MSTART: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = DIV_W'(r_sum) << (DIV_W - SUM_W);
                o_div_req.den   = 64'(r_rec.fill);
                o_div_req.bits  = DIV_CNT_W'(SUM_W);
            end
            S_VSTART: begin
                o_div_req.start = 1'b1;
                o_div_req.num   = r_acc;
                o_div_req.den   = 64'(r_rec.fill);
                o_div_req.bits  = DIV_CNT_W'(DIV_W);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (tag_rd_en) begin
            r_tag_q <= tag_mem[idx];
        end
        if (tag_wr_en) begin
            tag_mem[r_free] <= r_item.handle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ent_rd_en) begin
            r_ent_q <= ent_mem[r_e];
        end
        if (ent_wr_en) begin
            ent_mem[r_e] <= r_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_wr_en) begin
            win_mem[win_addr] <= iv;
        end else if (win_rd_en) begin
            r_win_q <= win_mem[win_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
            r_p1      <= 1'b0;
            r_p2      <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_o_valid || i_ready)) begin
                r_o_valid <= 1'b1;
                r_out     <= r_res;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item    <= i_q_item;
                        r_idx     <= '0;
                        r_found   <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == CNT_W'(TABLE_ENTRIES)) begin
                        r_state <= S_DECIDE;
                    end else if (r_valid[idx]) begin
                        r_state <= S_SCMP;
                    end else begin
                        if (!r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= idx;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCMP: begin
                    if (r_tag_q == r_item.handle) begin
                        r_found <= 1'b1;
                        r_e     <= idx;
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_DECIDE: begin
                    if (r_found) begin
                        r_new   <= 1'b0;
                        r_state <= S_ERD;
                    end else if (r_free_ok) begin
                        r_e              <= r_free;
                        r_new            <= 1'b1;
                        r_valid[r_free]  <= 1'b1;
                        r_state          <= S_ERD;
                    end else begin
                        r_res   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_ERD: begin
                    r_base  <= WADDR_W'(r_e * WINDOW_INTERVALS);
                    r_state <= S_EGET;
                end
                S_EGET: begin
                    r_rec.last  <= r_item.now;
                    r_rec.count <= new_count;
                    r_rec.freq  <= cur.freq;
                    r_rec.reuse <= cur.reuse;
                    r_rec.next  <= cur.next;
                    r_rec.fill  <= (push && cur.fill != FILL_W'(WINDOW_INTERVALS))
                                 ? cur.fill + 1'b1 : cur.fill;
                    r_rec.head  <= !push ? cur.head
                                 : (cur.head == HEAD_W'(WINDOW_INTERVALS - 1)) ? '0
                                 : cur.head + 1'b1;
                    r_prod    <= new_count * FREQ_SCALE;
                    r_elapsed <= r_item.now - i_start_time;
                    r_state   <= S_FSTART;
                end
                S_FSTART: begin
                    if (r_elapsed != '0) begin
                        r_ret   <= S_FDONE;
                        r_state <= S_DWAIT;
                    end else begin
                        r_state <= S_REUSE;
                    end
                end
                S_DWAIT: begin
                    if (i_div_done) begin
                        r_quot  <= i_div_quot;
                        r_state <= r_ret;
                    end
                end
                S_FDONE: begin
                    r_rec.freq <= (r_quot[DIV_W-1:32] != '0) ? '1 : r_quot[31:0];
                    r_state    <= S_REUSE;
                end
                S_REUSE: begin
                    if (r_rec.count > 32'd1) begin
                        r_rec.reuse <= reuse_value(r_rec.count);
                    end
                    r_pat <= PAT_UNKNOWN;
                    r_ri  <= '0;
                    r_sum <= '0;
                    r_acc <= '0;
                    r_state <= (r_rec.fill != '0) ? S_SUM : S_SSTART;
                end
                S_SUM: begin
                    if (win_rd_en) begin
                        r_ri <= r_ri + 1'b1;
                    end
                    r_p1 <= win_rd_en;
                    if (r_p1) begin
                        r_sum <= r_sum + SUM_W'(r_win_q);
                    end
                    if (!win_rd_en && !r_p1) begin
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_ret   <= S_MDONE;
                    r_state <= S_DWAIT;
                end
                S_MDONE: begin
                    r_mean     <= r_quot[31:0];
                    r_msq      <= r_quot[31:0] * r_quot[31:0];
                    r_rec.next <= r_item.now + 64'(r_quot[31:0]);
                    r_ri       <= '0;
                    if (r_rec.fill < FILL_W'(3)) begin
                        r_state <= S_SSTART;
                    end else if (r_quot[31:0] == '0) begin
                        r_pat   <= PAT_SEQ;
                        r_state <= S_SSTART;
                    end else begin
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (win_rd_en) begin
                        r_ri <= r_ri + 1'b1;
                    end
                    r_p1 <= win_rd_en;
                    r_p2 <= r_p1;
                    if (r_p1) begin
                        r_sq <= diff * diff;
                    end
                    if (r_p2) begin
                        r_acc <= r_acc + DIV_W'(r_sq);
                    end
                    if (!win_rd_en && !r_p1 && !r_p2) begin
                        r_state <= S_VSTART;
                    end
                end
                S_VSTART: begin
                    r_ret   <= S_CLS;
                    r_state <= S_DWAIT;
                end
                S_CLS: begin
                    r_v100  <= (DIV_W'(var_q) << 6) + (DIV_W'(var_q) << 5)
                             + (DIV_W'(var_q) << 2);
                    r_m9    <= (DIV_W'(r_msq) << 3) + DIV_W'(r_msq);
                    r_state <= S_CLS2;
                end
                S_CLS2: begin
                    priority if (r_v100 < DIV_W'(r_msq)) begin
                        r_pat <= PAT_SEQ;
                    end else if (r_v100 < r_m9) begin
                        r_pat <= PAT_STRIDED;
                    end else if (r_v100 < (r_m9 << 2)) begin
                        r_pat <= PAT_TEMPORAL;
                    end else begin
                        r_pat <= PAT_RANDOM;
                    end
                    r_state <= S_SSTART;
                end
                S_SSTART: begin
                    r_sprod <= 68'(smul);
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_sprod <= r_sprod + {smul, 17'b0};
                    r_state <= S_SDONE;
                end
                S_SDONE: begin
                    r_res.tracked <= 1'b1;
                    r_res.total   <= r_rec.count;
                    r_res.freq    <= r_rec.freq;
                    r_res.reuse   <= r_rec.reuse;
                    r_res.next    <= r_rec.next;
                    r_res.score   <= (score[33:32] != '0) ? '1 : score[31:0];
                    r_res.pattern <= r_pat;
                    r_state       <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid             = r_o_valid;
    assign o_tracked           = r_out.tracked;
    assign o_access_total      = r_out.total;
    assign o_access_frequency  = r_out.freq;
    assign o_reuse_probability = r_out.reuse;
    assign o_expected_next_us  = r_out.next;
    assign o_residency_score   = r_out.score;
    assign o_access_pattern    = r_out.pattern;

endmodule

/* design/access_hotness_pattern_tracker.sv */
// Access hotness and pattern tracker, top level.
// Depends on ahpt_pkg, ahpt_front, ahpt_queue, ahpt_divider and ahpt_back.
//
// One transaction in gives one result out. Transactions are taken into a
// two-deep queue and handled one at a time by the back engine: the handle
// search walks the table (a free entry is passed in SCAN alone, a used entry
// goes through SCAN and SCMP), the interval window is swept up to twice and
// the shared bit-serial divider runs up to three times; the residency score
// takes a multiply split into two halves. The time a transaction takes is set
// mostly by the table search, the window sweeps and the divider. The user must
// write start_time_us through the configuration port only while the block is
// idle; the block itself does not enforce this.
module access_hotness_pattern_tracker import ahpt_pkg::*; #(
    parameter int TABLE_ENTRIES    = 64,
    parameter int WINDOW_INTERVALS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_tensor_handle,
    input  logic [63:0] i_now_us,
    input  logic [31:0] i_compute_time_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_tracked,
    output logic [31:0] o_access_total,
    output logic [31:0] o_access_frequency,
    output logic [15:0] o_reuse_probability,
    output logic [63:0] o_expected_next_us,
    output logic [31:0] o_residency_score,
    output logic [2:0]  o_access_pattern
);

    logic             r_start_time;
    logic [63:0]      r_start_time_us;
    logic             f_push;
    t_item            f_item;
    logic             q_push_ready;
    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    t_div_req         div_req;
    logic             div_done;
    logic [DIV_W-1:0] div_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_time_us <= '0;
            r_start_time    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_start_time_us <= i_cfg_wr_data;
            r_start_time    <= 1'b1;
        end
    end

    ahpt_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_tensor_handle   (i_tensor_handle),
        .i_now_us          (i_now_us),
        .i_compute_time_us (i_compute_time_us),
        .o_push            (f_push),
        .o_item            (f_item),
        .i_push_ready      (q_push_ready)
    );

    ahpt_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (f_push),
        .i_item       (f_item),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_item       (q_item),
        .i_pop        (q_pop)
    );

    ahpt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ahpt_back #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .WINDOW_INTERVALS (WINDOW_INTERVALS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start_time        (r_start_time ? r_start_time_us : 64'd0),
        .i_q_valid           (q_valid),
        .i_q_item            (q_item),
        .o_q_pop             (q_pop),
        .o_div_req           (div_req),
        .i_div_done          (div_done),
        .i_div_quot          (div_quot),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_tracked           (o_tracked),
        .o_access_total      (o_access_total),
        .o_access_frequency  (o_access_frequency),
        .o_reuse_probability (o_reuse_probability),
        .o_expected_next_us  (o_expected_next_us),
        .o_residency_score   (o_residency_score),
        .o_access_pattern    (o_access_pattern)
    );

endmodule

/* design/ahpt_checker.sv */
// Port-level checks for the access hotness and pattern tracker, with bind.
// Depends on ahpt_pkg and access_hotness_pattern_tracker_assert.svh.
`include "access_hotness_pattern_tracker_assert.svh"

module ahpt_checker import ahpt_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_tracked,
    input logic [31:0] o_access_total,
    input logic [31:0] o_access_frequency,
    input logic [15:0] o_reuse_probability,
    input logic [63:0] o_expected_next_us,
    input logic [31:0] o_residency_score,
    input logic [2:0]  o_access_pattern
);

    `AHPT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_access_total) && $stable(o_expected_next_us) && $stable(o_tracked))

    `AHPT_ASSERT_IMPL(a_untracked_zero, i_clk, i_rst_n, o_valid && !o_tracked,
        o_access_total == 0 && o_access_frequency == 0 && o_reuse_probability == 0 && o_expected_next_us == 0 && o_residency_score == 0 && o_access_pattern == PAT_UNKNOWN)

    `AHPT_ASSERT_IMPL(a_tracked_sane, i_clk, i_rst_n, o_valid && o_tracked,
        o_access_total != 0 && o_reuse_probability <= REUSE_CAP)

    `AHPT_ASSERT_IMPL(a_first_access, i_clk, i_rst_n, o_valid && o_tracked && o_access_total == 1,
        o_reuse_probability == 0 && o_expected_next_us == 0 && o_access_pattern == PAT_UNKNOWN)

endmodule

bind access_hotness_pattern_tracker ahpt_checker u_ahpt_checker (.*);
